// ===== rtl/core/depth_pixel_deprojection_macros.svh =====
// Assertion macros shared by the deprojection checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DEPTH_PIXEL_DEPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_DEPROJECTION_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define DPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define DPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/dpd_pkg.sv =====
// Shared types and constants for the depth pixel deprojection block.
// No dependencies; used by every module of the block.
package dpd_pkg;

   // Raster limits
   localparam int MAX_COLUMNS = 4096;
   localparam int MAX_ROWS    = 4096;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);

   // Field widths
   localparam int RAW_W   = 16;
   localparam int Z_W     = 24;
   localparam int XY_W    = 32;
   localparam int SCALE_W = 24;
   localparam int PRIN_W  = 16;
   localparam int INV_W   = 24;
   localparam int STEP_W  = 5;
   localparam int PHASE_W = 4;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   // Queue sizes
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_AW      = $clog2(RSP_DEPTH);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEPTH_SCALE = 3'd0,
      CSR_PRINCIPAL_X = 3'd1,
      CSR_PRINCIPAL_Y = 3'd2,
      CSR_INV_FOCAL_X = 3'd3,
      CSR_INV_FOCAL_Y = 3'd4,
      CSR_MIN_RANGE   = 3'd5,
      CSR_MAX_RANGE   = 3'd6,
      CSR_SAMPLE_STEP = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SCALE_W-1:0] depth_scale;
      logic [PRIN_W-1:0]  principal_x;
      logic [PRIN_W-1:0]  principal_y;
      logic [INV_W-1:0]   inv_focal_x;
      logic [INV_W-1:0]   inv_focal_y;
      logic [Z_W-1:0]     min_range;
      logic [Z_W-1:0]     max_range;
      logic [STEP_W-1:0]  sample_step;
   } csr_type;

   // Pixel that passed the stride and raw-zero tests
   typedef struct packed {
      logic [RAW_W-1:0] raw;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } cand_type;

   typedef struct packed {
      logic [XY_W-1:0] x;
      logic [XY_W-1:0] y;
      logic [Z_W-1:0]  z;
   } point_type;

   // Handshake between the candidate queue and the back end
   typedef struct packed {
      logic     empty;
      cand_type head;
   } cand_q_type;

endpackage

// ===== rtl/core/dpd_front.sv =====
// Front end: raster column/row counters, stride gating and raw-zero filter.
// Depends on dpd_pkg; feeds dpd_queue.
module dpd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic                        q_full,
   input  logic [dpd_pkg::RAW_W-1:0]   depth_raw,
   input  logic                        frame_start,
   input  logic                        line_end,
   input  logic [dpd_pkg::STEP_W-1:0]  sample_step,
   output logic                        full,
   output logic                        cand_push,
   output dpd_pkg::cand_type           cand
);

   localparam logic [dpd_pkg::COL_W-1:0] COL_LAST = dpd_pkg::COL_W'(dpd_pkg::MAX_COLUMNS - 1);
   localparam logic [dpd_pkg::ROW_W-1:0] ROW_LAST = dpd_pkg::ROW_W'(dpd_pkg::MAX_ROWS - 1);
   localparam logic [dpd_pkg::STEP_W-1:0] STEP_MAX = dpd_pkg::STEP_W'(16);

   logic [dpd_pkg::COL_W-1:0]   col_ff, col_in, cur_col;
   logic [dpd_pkg::ROW_W-1:0]   row_ff, row_in, cur_row;
   logic [dpd_pkg::PHASE_W-1:0] cph_ff, cph_in, cur_cph;
   logic [dpd_pkg::PHASE_W-1:0] rph_ff, rph_in, cur_rph;
   logic [dpd_pkg::STEP_W-1:0]  eff_step;
   logic                        accept;

   function automatic logic [dpd_pkg::PHASE_W-1:0] next_phase(
      input logic [dpd_pkg::PHASE_W-1:0] ph,
      input logic [dpd_pkg::STEP_W-1:0]  stp
   );
      logic [dpd_pkg::STEP_W-1:0] nx;
      nx = dpd_pkg::STEP_W'(ph) + dpd_pkg::STEP_W'(1);
      if (nx >= stp) nx = '0;
      return nx[dpd_pkg::PHASE_W-1:0];
   endfunction

   assign full   = q_full;
   assign accept = push & ~q_full;

   // Clamp the stride into 1..16
   always_comb begin
      if (sample_step == '0) eff_step = dpd_pkg::STEP_W'(1);
      else if (sample_step > STEP_MAX) eff_step = STEP_MAX;
      else eff_step = sample_step;
   end

   // Position of this pixel; frame start restarts the raster
   assign cur_col = frame_start ? '0 : col_ff;
   assign cur_row = frame_start ? '0 : row_ff;
   assign cur_cph = frame_start ? '0 : cph_ff;
   assign cur_rph = frame_start ? '0 : rph_ff;

   // Forward pixels on the stride with a measurement
   assign cand_push = accept && (cur_cph == '0) && (cur_rph == '0) && (depth_raw != '0);
   assign cand.raw  = depth_raw;
   assign cand.col  = cur_col;
   assign cand.row  = cur_row;

   // Advance counters after the pixel, holding at the raster limit
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cph_in = cph_ff;
      rph_in = rph_ff;
      if (accept) begin
         if (line_end) begin
            col_in = '0;
            cph_in = '0;
            row_in = (cur_row != ROW_LAST) ? cur_row + dpd_pkg::ROW_W'(1) : cur_row;
            rph_in = next_phase(cur_rph, eff_step);
         end else begin
            row_in = cur_row;
            rph_in = cur_rph;
            col_in = (cur_col != COL_LAST) ? cur_col + dpd_pkg::COL_W'(1) : cur_col;
            cph_in = next_phase(cur_cph, eff_step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cph_ff <= cph_in;
         rph_ff <= rph_in;
      end
   end

endmodule

// ===== rtl/core/dpd_queue.sv =====
// Short candidate queue between the front end and the arithmetic back end.
// Depends on dpd_pkg.
module dpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  dpd_pkg::cand_type   wr_data,
   input  logic                rd_en,
   output logic                q_full,
   output dpd_pkg::cand_q_type q_out
);

   dpd_pkg::cand_type              slot_ff [dpd_pkg::QUEUE_DEPTH];
   logic [dpd_pkg::QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [dpd_pkg::QUEUE_AW:0]     cnt_ff, cnt_in;

   assign q_full      = (cnt_ff == (dpd_pkg::QUEUE_AW+1)'(dpd_pkg::QUEUE_DEPTH));
   assign q_out.empty = (cnt_ff == '0);
   assign q_out.head  = slot_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (wr_en && !rd_en) cnt_in = cnt_ff + (dpd_pkg::QUEUE_AW+1)'(1);
      if (!wr_en && rd_en) cnt_in = cnt_ff - (dpd_pkg::QUEUE_AW+1)'(1);
   end

   // Store the new candidate
   always_ff @(posedge clock) begin
      if (wr_en) slot_ff[wr_ptr_ff] <= wr_data;
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + dpd_pkg::QUEUE_AW'(1);
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + dpd_pkg::QUEUE_AW'(1);
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/dpd_back.sv =====
// Back end: depth scaling, range test, lateral products and saturation,
// then the result queue. Depends on dpd_pkg; reads from dpd_queue.
module dpd_back (
   input  logic                clock,
   input  logic                reset,
   input  dpd_pkg::csr_type    csr,
   input  dpd_pkg::cand_q_type q_in,
   output logic                q_pop,
   input  logic                pop,
   output logic                empty,
   output dpd_pkg::point_type  rsp
);

   localparam int PROD_W  = dpd_pkg::RAW_W + dpd_pkg::SCALE_W;
   localparam int Z_SHIFT = 8;
   localparam int ZQ_W    = PROD_W - Z_SHIFT;
   localparam int CNT_W   = (dpd_pkg::COL_W > dpd_pkg::ROW_W) ? dpd_pkg::COL_W : dpd_pkg::ROW_W;
   localparam int PIX_W   = CNT_W + 4;
   localparam int OFS_W   = ((PIX_W > dpd_pkg::PRIN_W) ? PIX_W : dpd_pkg::PRIN_W) + 1;
   localparam int MAG_W   = OFS_W - 1;
   localparam int PZ_W    = MAG_W + dpd_pkg::Z_W;
   localparam int LO_W    = PZ_W / 2;
   localparam int HI_W    = PZ_W - LO_W;
   localparam int FULL_W  = PZ_W + dpd_pkg::INV_W;
   localparam int Q_SHIFT = 28;
   localparam int Q_W     = FULL_W - Q_SHIFT;
   localparam int OCC_W   = dpd_pkg::RSP_AW + 1;
   localparam logic [Q_W-1:0] NEG_LIM = Q_W'(1) << (dpd_pkg::XY_W - 1);
   localparam logic [Q_W-1:0] POS_LIM = NEG_LIM - Q_W'(1);

   // Stage 1: raw times scale
   logic                        s1_v_ff;
   logic [PROD_W-1:0]           s1_prod_ff;
   logic [dpd_pkg::COL_W-1:0]   s1_col_ff;
   logic [dpd_pkg::ROW_W-1:0]   s1_row_ff;
   // Stage 2: z, range test, offsets
   logic                        s2_v_ff, s2_keep_ff, s2_negx_ff, s2_negy_ff;
   logic [dpd_pkg::Z_W-1:0]     s2_z_ff;
   logic [MAG_W-1:0]            s2_magx_ff, s2_magy_ff;
   // Stage 3: offset times z
   logic                        s3_v_ff, s3_keep_ff, s3_negx_ff, s3_negy_ff;
   logic [dpd_pkg::Z_W-1:0]     s3_z_ff;
   logic [PZ_W-1:0]             s3_pzx_ff, s3_pzy_ff;
   // Stage 4: partial products with the reciprocal focal length
   logic                        s4_v_ff, s4_keep_ff, s4_negx_ff, s4_negy_ff;
   logic [dpd_pkg::Z_W-1:0]     s4_z_ff;
   logic [LO_W+dpd_pkg::INV_W-1:0] s4_xlo_ff, s4_ylo_ff;
   logic [HI_W+dpd_pkg::INV_W-1:0] s4_xhi_ff, s4_yhi_ff;

   logic [ZQ_W-1:0]             zq;
   logic [dpd_pkg::Z_W-1:0]     z_sat;
   logic                        z_keep;
   logic [OFS_W-1:0]            ofsx, ofsy;
   logic [FULL_W-1:0]           fullx, fully;
   dpd_pkg::point_type          result;
   logic                        res_push, res_drop, rsp_take;

   // Result queue and slot reservation
   dpd_pkg::point_type          res_ff [dpd_pkg::RSP_DEPTH];
   logic [dpd_pkg::RSP_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [OCC_W-1:0]            cnt_ff, cnt_in, occ_ff, occ_in;

   function automatic logic [dpd_pkg::XY_W-1:0] sat_lateral(
      input logic           neg,
      input logic [Q_W-1:0] q
   );
      logic [Q_W-1:0] lim;
      lim = q;
      if (neg) begin
         if (q > NEG_LIM) lim = NEG_LIM;
         return dpd_pkg::XY_W'(0) - lim[dpd_pkg::XY_W-1:0];
      end
      if (q > POS_LIM) lim = POS_LIM;
      return lim[dpd_pkg::XY_W-1:0];
   endfunction

   // Launch a candidate only when a result slot is reserved for it
   assign q_pop    = !q_in.empty && (occ_ff < OCC_W'(dpd_pkg::RSP_DEPTH));
   assign rsp_take = pop && !empty;

   // Stage 2 logic: truncate, saturate and range-test z, and form the pixel offsets
   assign zq     = ZQ_W'(s1_prod_ff >> Z_SHIFT);
   assign z_sat  = (zq[ZQ_W-1:dpd_pkg::Z_W] != '0) ? '1 : zq[dpd_pkg::Z_W-1:0];
   assign z_keep = (z_sat >= csr.min_range) &&
                   !((csr.max_range != '0) && (z_sat > csr.max_range));
   assign ofsx   = OFS_W'({s1_col_ff, 4'b0000}) - OFS_W'(csr.principal_x);
   assign ofsy   = OFS_W'({s1_row_ff, 4'b0000}) - OFS_W'(csr.principal_y);

   // Final stage: combine partials, shift to Q.16, saturate
   assign fullx = {s4_xhi_ff, {LO_W{1'b0}}} + FULL_W'(s4_xlo_ff);
   assign fully = {s4_yhi_ff, {LO_W{1'b0}}} + FULL_W'(s4_ylo_ff);
   assign result.x = sat_lateral(s4_negx_ff, fullx[FULL_W-1:Q_SHIFT]);
   assign result.y = sat_lateral(s4_negy_ff, fully[FULL_W-1:Q_SHIFT]);
   assign result.z = s4_z_ff;
   assign res_push = s4_v_ff && s4_keep_ff;
   assign res_drop = s4_v_ff && !s4_keep_ff;

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= q_pop;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      s1_prod_ff <= PROD_W'(q_in.head.raw) * PROD_W'(csr.depth_scale);
      s1_col_ff  <= q_in.head.col;
      s1_row_ff  <= q_in.head.row;

      s2_keep_ff <= z_keep;
      s2_z_ff    <= z_sat;
      s2_negx_ff <= ofsx[OFS_W-1];
      s2_negy_ff <= ofsy[OFS_W-1];
      s2_magx_ff <= ofsx[OFS_W-1] ? MAG_W'(-ofsx) : ofsx[MAG_W-1:0];
      s2_magy_ff <= ofsy[OFS_W-1] ? MAG_W'(-ofsy) : ofsy[MAG_W-1:0];

      s3_keep_ff <= s2_keep_ff;
      s3_z_ff    <= s2_z_ff;
      s3_negx_ff <= s2_negx_ff;
      s3_negy_ff <= s2_negy_ff;
      s3_pzx_ff  <= PZ_W'(s2_magx_ff) * PZ_W'(s2_z_ff);
      s3_pzy_ff  <= PZ_W'(s2_magy_ff) * PZ_W'(s2_z_ff);

      s4_keep_ff <= s3_keep_ff;
      s4_z_ff    <= s3_z_ff;
      s4_negx_ff <= s3_negx_ff;
      s4_negy_ff <= s3_negy_ff;
      s4_xlo_ff  <= (LO_W+dpd_pkg::INV_W)'(s3_pzx_ff[LO_W-1:0]) *
                    (LO_W+dpd_pkg::INV_W)'(csr.inv_focal_x);
      s4_xhi_ff  <= (HI_W+dpd_pkg::INV_W)'(s3_pzx_ff[PZ_W-1:LO_W]) *
                    (HI_W+dpd_pkg::INV_W)'(csr.inv_focal_x);
      s4_ylo_ff  <= (LO_W+dpd_pkg::INV_W)'(s3_pzy_ff[LO_W-1:0]) *
                    (LO_W+dpd_pkg::INV_W)'(csr.inv_focal_y);
      s4_yhi_ff  <= (HI_W+dpd_pkg::INV_W)'(s3_pzy_ff[PZ_W-1:LO_W]) *
                    (HI_W+dpd_pkg::INV_W)'(csr.inv_focal_y);
   end

   // Track reserved slots: launched points not yet dropped or delivered
   always_comb begin
      occ_in = occ_ff + OCC_W'(q_pop) - OCC_W'(res_drop) - OCC_W'(rsp_take);
      cnt_in = cnt_ff + OCC_W'(res_push) - OCC_W'(rsp_take);
   end

   // Store finished points
   always_ff @(posedge clock) begin
      if (res_push) res_ff[wr_ptr_ff] <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         occ_ff    <= '0;
      end else begin
         if (res_push) wr_ptr_ff <= wr_ptr_ff + dpd_pkg::RSP_AW'(1);
         if (rsp_take) rd_ptr_ff <= rd_ptr_ff + dpd_pkg::RSP_AW'(1);
         cnt_ff <= cnt_in;
         occ_ff <= occ_in;
      end
   end

   assign empty = (cnt_ff == '0);
   assign rsp   = res_ff[rd_ptr_ff];

endmodule

// ===== rtl/core/depth_pixel_deprojection.sv =====
// A kept pixel passes the candidate queue, back-end pipeline and result queue.
// Throughput: one pixel per cycle while full is low; the front gates pixels into a
// 4-entry queue and the back end launches one candidate per cycle while its 8-entry
// result queue has a reserved slot; a stalled consumer fills both and then sets full.
// Reset: synchronous, active high; clears counters, queues and in-flight points,
// and loads the configuration registers with their defaults.
module depth_pixel_deprojection (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [dpd_pkg::RAW_W-1:0]           req_depth_raw,
   input  logic                                req_frame_start,
   input  logic                                req_line_end,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [dpd_pkg::XY_W-1:0]     rsp_point_x,
   output logic signed [dpd_pkg::XY_W-1:0]     rsp_point_y,
   output logic [dpd_pkg::Z_W-1:0]             rsp_point_z,
   input  logic                                csr_write,
   input  logic [dpd_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [dpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam dpd_pkg::csr_type CSR_DEFAULT = '{
      depth_scale: dpd_pkg::SCALE_W'(16777),
      principal_x: dpd_pkg::PRIN_W'(5120),
      principal_y: dpd_pkg::PRIN_W'(3840),
      inv_focal_x: dpd_pkg::INV_W'(27962),
      inv_focal_y: dpd_pkg::INV_W'(27962),
      min_range:   dpd_pkg::Z_W'(0),
      max_range:   dpd_pkg::Z_W'(0),
      sample_step: dpd_pkg::STEP_W'(1)
   };

   dpd_pkg::csr_type    csr_ff, csr_in;
   dpd_pkg::cand_type   cand;
   dpd_pkg::cand_q_type q_out;
   dpd_pkg::point_type  rsp;
   logic                cand_push, q_full, q_pop;

   // Decode register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (dpd_pkg::csr_index_type'(csr_index))
            dpd_pkg::CSR_DEPTH_SCALE: csr_in.depth_scale = csr_wdata[dpd_pkg::SCALE_W-1:0];
            dpd_pkg::CSR_PRINCIPAL_X: csr_in.principal_x = csr_wdata[dpd_pkg::PRIN_W-1:0];
            dpd_pkg::CSR_PRINCIPAL_Y: csr_in.principal_y = csr_wdata[dpd_pkg::PRIN_W-1:0];
            dpd_pkg::CSR_INV_FOCAL_X: csr_in.inv_focal_x = csr_wdata[dpd_pkg::INV_W-1:0];
            dpd_pkg::CSR_INV_FOCAL_Y: csr_in.inv_focal_y = csr_wdata[dpd_pkg::INV_W-1:0];
            dpd_pkg::CSR_MIN_RANGE:   csr_in.min_range   = csr_wdata[dpd_pkg::Z_W-1:0];
            dpd_pkg::CSR_MAX_RANGE:   csr_in.max_range   = csr_wdata[dpd_pkg::Z_W-1:0];
            dpd_pkg::CSR_SAMPLE_STEP: csr_in.sample_step = csr_wdata[dpd_pkg::STEP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_DEFAULT;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Count the raster and gate pixels
   dpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .q_full      (q_full),
      .depth_raw   (req_depth_raw),
      .frame_start (req_frame_start),
      .line_end    (req_line_end),
      .sample_step (csr_ff.sample_step),
      .full        (full),
      .cand_push   (cand_push),
      .cand        (cand)
   );

   // Decouple the front from the arithmetic
   dpd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cand_push),
      .wr_data (cand),
      .rd_en   (q_pop),
      .q_full  (q_full),
      .q_out   (q_out)
   );

   // Deproject and queue results
   dpd_back u_back (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ff),
      .q_in  (q_out),
      .q_pop (q_pop),
      .pop   (pop),
      .empty (empty),
      .rsp   (rsp)
   );

   assign rsp_point_x = rsp.x;
   assign rsp_point_y = rsp.y;
   assign rsp_point_z = rsp.z;

endmodule

// ===== rtl/core/dpd_checker.sv =====
// Port-level checker for depth_pixel_deprojection, attached by bind.
// Depends on dpd_pkg and depth_pixel_deprojection_macros.svh.
`include "depth_pixel_deprojection_macros.svh"

module dpd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            full,
   input logic                            empty,
   input logic                            pop,
   input logic signed [dpd_pkg::XY_W-1:0] rsp_point_x,
   input logic signed [dpd_pkg::XY_W-1:0] rsp_point_y,
   input logic [dpd_pkg::Z_W-1:0]         rsp_point_z
);

   // Leave reset with both queues drained
   `DPD_ASSERT_IMPLY(a_reset_drains, clock, reset, $past(reset), empty && !full)

   // A point at zero depth lies on the optical axis
   `DPD_ASSERT_IMPLY(a_zero_depth_axis, clock, reset, !empty && (rsp_point_z == '0), (rsp_point_x == '0) && (rsp_point_y == '0))

   // Keep a waiting result until it is taken
   `DPD_ASSERT_NEXT(a_result_held, clock, reset, !empty && !pop, !empty)

   // Hold the waiting result's payload
   `DPD_ASSERT_NEXT(a_payload_held, clock, reset, !empty && !pop, $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_point_z))

endmodule

bind depth_pixel_deprojection dpd_checker u_dpd_checker (.*);

// ===== bench/depth_pixel_deprojection_tb.sv =====
// Self-checking bench for depth_pixel_deprojection: depth pixels in, camera points out.
// Depends on dpd_pkg and the block's RTL; carries its own fixed-point point model.
`timescale 1ns / 1ps

module depth_pixel_deprojection_tb;

   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_STALL   = 400;
   localparam int PHASE_ITEMS  = 90;
   localparam int PHASE_COUNT  = 8;
   localparam int TAIL_ITEMS   = 28;
   localparam int SHOW_LIMIT   = 10;

   typedef enum {ROW_PIXEL, ROW_WRITE} row_kind_type;
   typedef enum {PT_PREDICTED, PT_NONE, PT_GIVEN} point_check_type;

   // One line of the directed stimulus: a register write or a pixel
   typedef struct {
      row_kind_type                   kind;
      dpd_pkg::csr_index_type         reg_idx;
      logic [dpd_pkg::CSR_DATA_W-1:0] value;
      logic [dpd_pkg::RAW_W-1:0]      raw;
      logic                           frame_start;
      logic                           line_end;
      point_check_type                check;
      dpd_pkg::point_type             given;
   } stim_row_type;

   logic                           clock           = 1'b0;
   logic                           reset           = 1'b1;
   logic                           push            = 1'b0;
   logic                           full;
   logic [dpd_pkg::RAW_W-1:0]      req_depth_raw   = '0;
   logic                           req_frame_start = 1'b0;
   logic                           req_line_end    = 1'b0;
   logic                           empty;
   logic                           pop             = 1'b0;
   logic signed [dpd_pkg::XY_W-1:0] rsp_point_x;
   logic signed [dpd_pkg::XY_W-1:0] rsp_point_y;
   logic [dpd_pkg::Z_W-1:0]        rsp_point_z;
   logic                           csr_write       = 1'b0;
   logic [dpd_pkg::CSR_ADDR_W-1:0] csr_index       = '0;
   logic [dpd_pkg::CSR_DATA_W-1:0] csr_wdata       = '0;

   // Model copy of registers and raster counters
   dpd_pkg::csr_type            cfg_mirror;
   logic [dpd_pkg::COL_W-1:0]   col_count;
   logic [dpd_pkg::ROW_W-1:0]   row_count;
   logic [dpd_pkg::PHASE_W-1:0] col_phase;
   logic [dpd_pkg::PHASE_W-1:0] row_phase;

   dpd_pkg::point_type pending_points[$];
   stim_row_type       stim_rows[$];

   // Raster position of the random frame generator, kept across phases
   int gen_col    = 0;
   int gen_row    = 0;
   int gen_width  = 1;
   int gen_height = 1;

   bit tx_steady    = 1'b0;
   bit rx_steady    = 1'b0;
   bit hold_request = 1'b0;

   int error_count      = 0;
   int pixels_sent      = 0;
   int points_checked   = 0;
   int settings_applied = 0;
   int long_stalls      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   depth_pixel_deprojection uut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_depth_raw   (req_depth_raw),
      .req_frame_start (req_frame_start),
      .req_line_end    (req_line_end),
      .empty           (empty),
      .pop             (pop),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   function automatic dpd_pkg::csr_type reset_settings();
      dpd_pkg::csr_type s;
      s.depth_scale = 24'd16777;
      s.principal_x = 16'd5120;
      s.principal_y = 16'd3840;
      s.inv_focal_x = 24'd27962;
      s.inv_focal_y = 24'd27962;
      s.min_range   = 24'd0;
      s.max_range   = 24'd0;
      s.sample_step = 5'd1;
      return s;
   endfunction

   // Advance a stride phase; clamp the step to 1..16 and wrap at or past it
   function automatic logic [dpd_pkg::PHASE_W-1:0] next_phase(
      logic [dpd_pkg::PHASE_W-1:0] phase
   );
      logic [dpd_pkg::STEP_W-1:0] stride;
      logic [dpd_pkg::STEP_W-1:0] bumped;
      stride = (cfg_mirror.sample_step == 0) ? 5'd1 :
               (cfg_mirror.sample_step > 16) ? 5'd16 : cfg_mirror.sample_step;
      bumped = {1'b0, phase} + 5'd1;
      return (bumped >= stride) ? '0 : bumped[dpd_pkg::PHASE_W-1:0];
   endfunction

   // Lateral coordinate: (pixel*16 - principal) * z * inv_focal, Q.44 -> Q15.16,
   // magnitude truncated toward zero, then signed and saturated
   function automatic logic [dpd_pkg::XY_W-1:0] lateral_coord(
      logic [dpd_pkg::COL_W-1:0]  pixel,
      logic [dpd_pkg::PRIN_W-1:0] principal,
      logic [dpd_pkg::Z_W-1:0]    z,
      logic [dpd_pkg::INV_W-1:0]  inv_focal
   );
      logic signed [17:0] offset;
      logic [17:0]        magnitude;
      logic [63:0]        product;
      logic [35:0]        scaled;
      offset    = $signed({2'b00, pixel, 4'b0000}) - $signed({2'b00, principal});
      magnitude = offset[17] ? 18'(-offset) : 18'(offset);
      product   = 64'(magnitude) * 64'(z) * 64'(inv_focal);
      scaled    = product[63:28];
      if (offset[17]) begin
         if (scaled > 36'h080000000) scaled = 36'h080000000;
         return -scaled[dpd_pkg::XY_W-1:0];
      end
      if (scaled > 36'h07FFFFFFF) scaled = 36'h07FFFFFFF;
      return scaled[dpd_pkg::XY_W-1:0];
   endfunction

   // Deproject one accepted pixel and step the raster counters
   task automatic deproject_pixel(input logic [dpd_pkg::RAW_W-1:0] raw,
                                  input logic frame_start, input logic line_end,
                                  output bit kept, output dpd_pkg::point_type pt);
      logic [39:0]             raw_scaled;
      logic [dpd_pkg::Z_W-1:0] z;
      kept = 1'b0;
      pt   = '0;
      if (frame_start) begin
         col_count = '0;
         row_count = '0;
         col_phase = '0;
         row_phase = '0;
      end
      if (col_phase == 0 && row_phase == 0 && raw != 0) begin
         raw_scaled = 40'(raw) * 40'(cfg_mirror.depth_scale);
         z = (raw_scaled[39:8] > 32'hFFFFFF) ? 24'hFFFFFF : raw_scaled[31:8];
         kept = (z >= cfg_mirror.min_range) &&
                !(cfg_mirror.max_range != 0 && z > cfg_mirror.max_range);
         pt.x = lateral_coord(col_count, cfg_mirror.principal_x, z, cfg_mirror.inv_focal_x);
         pt.y = lateral_coord(row_count, cfg_mirror.principal_y, z, cfg_mirror.inv_focal_y);
         pt.z = z;
      end
      if (line_end) begin
         col_count = '0;
         col_phase = '0;
         if (row_count < dpd_pkg::MAX_ROWS - 1) row_count = row_count + 1'b1;
         row_phase = next_phase(row_phase);
      end else begin
         if (col_count < dpd_pkg::MAX_COLUMNS - 1) col_count = col_count + 1'b1;
         col_phase = next_phase(col_phase);
      end
   endtask

   // Offer one pixel after a random gap and hold it until the block takes it
   task automatic send_pixel(input logic [dpd_pkg::RAW_W-1:0] raw, input logic frame_start,
                             input logic line_end,
                             input point_check_type check = PT_PREDICTED,
                             input dpd_pkg::point_type given = '0);
      int                 gap;
      bit                 kept;
      dpd_pkg::point_type pt;
      gap = tx_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push            <= 1'b1;
      req_depth_raw   <= raw;
      req_frame_start <= frame_start;
      req_line_end    <= line_end;
      @(posedge clock);
      while (full) @(posedge clock);
      deproject_pixel(raw, frame_start, line_end, kept, pt);
      if (check == PT_GIVEN) pending_points.push_back(given);
      else if (check == PT_PREDICTED && kept) pending_points.push_back(pt);
      pixels_sent++;
   endtask

   // Drop push, wait for every expected point, then let dropped pixels clear
   task automatic drain_points();
      push <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register once the block is idle
   task automatic write_reg(input dpd_pkg::csr_index_type idx,
                            input logic [dpd_pkg::CSR_DATA_W-1:0] value);
      drain_points();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         dpd_pkg::CSR_DEPTH_SCALE: cfg_mirror.depth_scale = value[dpd_pkg::SCALE_W-1:0];
         dpd_pkg::CSR_PRINCIPAL_X: cfg_mirror.principal_x = value[dpd_pkg::PRIN_W-1:0];
         dpd_pkg::CSR_PRINCIPAL_Y: cfg_mirror.principal_y = value[dpd_pkg::PRIN_W-1:0];
         dpd_pkg::CSR_INV_FOCAL_X: cfg_mirror.inv_focal_x = value[dpd_pkg::INV_W-1:0];
         dpd_pkg::CSR_INV_FOCAL_Y: cfg_mirror.inv_focal_y = value[dpd_pkg::INV_W-1:0];
         dpd_pkg::CSR_MIN_RANGE:   cfg_mirror.min_range   = value[dpd_pkg::Z_W-1:0];
         dpd_pkg::CSR_MAX_RANGE:   cfg_mirror.max_range   = value[dpd_pkg::Z_W-1:0];
         dpd_pkg::CSR_SAMPLE_STEP: cfg_mirror.sample_step = value[dpd_pkg::STEP_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input dpd_pkg::csr_type s);
      write_reg(dpd_pkg::CSR_DEPTH_SCALE, s.depth_scale);
      write_reg(dpd_pkg::CSR_PRINCIPAL_X, dpd_pkg::CSR_DATA_W'(s.principal_x));
      write_reg(dpd_pkg::CSR_PRINCIPAL_Y, dpd_pkg::CSR_DATA_W'(s.principal_y));
      write_reg(dpd_pkg::CSR_INV_FOCAL_X, s.inv_focal_x);
      write_reg(dpd_pkg::CSR_INV_FOCAL_Y, s.inv_focal_y);
      write_reg(dpd_pkg::CSR_MIN_RANGE, s.min_range);
      write_reg(dpd_pkg::CSR_MAX_RANGE, s.max_range);
      write_reg(dpd_pkg::CSR_SAMPLE_STEP, dpd_pkg::CSR_DATA_W'(s.sample_step));
      settings_applied++;
   endtask

   // Random 24-bit value with a random magnitude
   function automatic logic [dpd_pkg::CSR_DATA_W-1:0] spread24();
      logic [31:0] mask;
      logic [31:0] value;
      mask  = (32'h1 << $urandom_range(0, 24)) - 32'h1;
      value = $urandom;
      return value[dpd_pkg::CSR_DATA_W-1:0] & mask[dpd_pkg::CSR_DATA_W-1:0];
   endfunction

   // Raw depth with extra weight on zero, full scale and tiny values
   function automatic logic [dpd_pkg::RAW_W-1:0] random_raw();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return dpd_pkg::RAW_W'($urandom_range(1, 15));
         default: return dpd_pkg::RAW_W'($urandom);
      endcase
   endfunction

   // Stream well-formed frames of random size, with the odd broken mark
   task automatic stream_frames(input int count);
      logic fs;
      logic le;
      for (int i = 0; i < count; i++) begin
         if (gen_col == 0 && gen_row == 0) begin
            gen_width  = $urandom_range(1, 24);
            gen_height = $urandom_range(1, 8);
         end
         fs = (gen_col == 0 && gen_row == 0);
         le = (gen_col == gen_width - 1);
         if ($urandom_range(0, 15) == 0) begin
            fs = 1'($urandom_range(0, 1));
            le = 1'($urandom_range(0, 1));
         end
         send_pixel(random_raw(), fs, le);
         if (gen_col == gen_width - 1) begin
            gen_col = 0;
            gen_row = (gen_row == gen_height - 1) ? 0 : gen_row + 1;
         end else begin
            gen_col++;
         end
      end
   endtask

   task automatic add_pixel_row(input logic [dpd_pkg::RAW_W-1:0] raw, input logic fs,
                                input logic le, input point_check_type check,
                                input dpd_pkg::point_type given = '0);
      stim_row_type row;
      row.kind        = ROW_PIXEL;
      row.reg_idx     = dpd_pkg::CSR_DEPTH_SCALE;
      row.value       = '0;
      row.raw         = raw;
      row.frame_start = fs;
      row.line_end    = le;
      row.check       = check;
      row.given       = given;
      stim_rows.push_back(row);
   endtask

   task automatic add_write_row(input dpd_pkg::csr_index_type idx,
                                input logic [dpd_pkg::CSR_DATA_W-1:0] value);
      stim_row_type row;
      row.kind        = ROW_WRITE;
      row.reg_idx     = idx;
      row.value       = value;
      row.raw         = '0;
      row.frame_start = 1'b0;
      row.line_end    = 1'b0;
      row.check       = PT_NONE;
      row.given       = '0;
      stim_rows.push_back(row);
   endtask

   // Stimulus: directed table, random phases, then long-line and short-line runs
   initial begin : stimulus
      dpd_pkg::csr_type s;
      cfg_mirror = reset_settings();
      col_count  = '0;
      row_count  = '0;
      col_phase  = '0;
      row_phase  = '0;

      // Reset defaults: raw zero is dropped, the rest come from the model
      add_pixel_row(16'd1000, 1'b1, 1'b0, PT_PREDICTED);
      add_pixel_row(16'd0, 1'b0, 1'b0, PT_NONE);
      add_pixel_row(16'hFFFF, 1'b0, 1'b1, PT_PREDICTED);
      add_pixel_row(16'd2000, 1'b0, 1'b0, PT_PREDICTED);
      // Unit scale, principal at origin: z equals raw, origin pixel gives x = y = 0
      add_write_row(dpd_pkg::CSR_DEPTH_SCALE, 24'd256);
      add_write_row(dpd_pkg::CSR_PRINCIPAL_X, 24'd0);
      add_write_row(dpd_pkg::CSR_PRINCIPAL_Y, 24'd0);
      add_write_row(dpd_pkg::CSR_INV_FOCAL_X, 24'h100000);
      add_write_row(dpd_pkg::CSR_INV_FOCAL_Y, 24'h100000);
      add_pixel_row(16'hFFFF, 1'b1, 1'b0, PT_GIVEN, {32'h0, 32'h0, 24'd65535});
      add_pixel_row(16'd1, 1'b1, 1'b0, PT_GIVEN, {32'h0, 32'h0, 24'd1});
      add_pixel_row(16'd300, 1'b0, 1'b0, PT_PREDICTED);
      add_pixel_row(16'd400, 1'b0, 1'b1, PT_PREDICTED);
      add_pixel_row(16'd500, 1'b0, 1'b0, PT_PREDICTED);
      // Range limits at their edges
      add_write_row(dpd_pkg::CSR_MIN_RANGE, 24'd1000);
      add_pixel_row(16'd999, 1'b1, 1'b0, PT_NONE);
      add_pixel_row(16'd1000, 1'b1, 1'b0, PT_GIVEN, {32'h0, 32'h0, 24'd1000});
      add_write_row(dpd_pkg::CSR_MAX_RANGE, 24'd2000);
      add_pixel_row(16'd2001, 1'b1, 1'b0, PT_NONE);
      add_pixel_row(16'd2000, 1'b1, 1'b0, PT_GIVEN, {32'h0, 32'h0, 24'd2000});
      // Stride of two: off-stride columns and rows are dropped
      add_write_row(dpd_pkg::CSR_MIN_RANGE, 24'd0);
      add_write_row(dpd_pkg::CSR_MAX_RANGE, 24'd0);
      add_write_row(dpd_pkg::CSR_SAMPLE_STEP, 24'd2);
      add_pixel_row(16'd100, 1'b1, 1'b0, PT_GIVEN, {32'h0, 32'h0, 24'd100});
      add_pixel_row(16'd100, 1'b0, 1'b0, PT_NONE);
      add_pixel_row(16'd100, 1'b0, 1'b1, PT_PREDICTED);
      add_pixel_row(16'd100, 1'b0, 1'b1, PT_NONE);
      add_pixel_row(16'd100, 1'b0, 1'b0, PT_PREDICTED);
      // A step of zero acts as one
      add_write_row(dpd_pkg::CSR_SAMPLE_STEP, 24'd0);
      add_pixel_row(16'd100, 1'b1, 1'b0, PT_GIVEN, {32'h0, 32'h0, 24'd100});
      add_pixel_row(16'd100, 1'b0, 1'b0, PT_PREDICTED);
      // Everything at full scale: z and both lateral terms saturate
      add_write_row(dpd_pkg::CSR_SAMPLE_STEP, 24'd31);
      add_write_row(dpd_pkg::CSR_PRINCIPAL_X, 24'hFFFF);
      add_write_row(dpd_pkg::CSR_PRINCIPAL_Y, 24'hFFFF);
      add_write_row(dpd_pkg::CSR_INV_FOCAL_X, 24'hFFFFFF);
      add_write_row(dpd_pkg::CSR_INV_FOCAL_Y, 24'hFFFFFF);
      add_write_row(dpd_pkg::CSR_DEPTH_SCALE, 24'hFFFFFF);
      add_pixel_row(16'hFFFF, 1'b1, 1'b0, PT_GIVEN,
                    {32'h80000000, 32'h80000000, 24'hFFFFFF});
      add_pixel_row(16'd0, 1'b0, 1'b0, PT_NONE);
      add_write_row(dpd_pkg::CSR_PRINCIPAL_X, 24'd0);
      add_write_row(dpd_pkg::CSR_PRINCIPAL_Y, 24'd0);
      add_write_row(dpd_pkg::CSR_SAMPLE_STEP, 24'd1);
      add_pixel_row(16'hFFFF, 1'b1, 1'b0, PT_GIVEN, {32'h0, 32'h0, 24'hFFFFFF});
      add_pixel_row(16'hFFFF, 1'b0, 1'b0, PT_PREDICTED);
      add_pixel_row(16'h8000, 1'b0, 1'b1, PT_PREDICTED);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_WRITE) begin
            write_reg(stim_rows[i].reg_idx, stim_rows[i].value);
         end else begin
            send_pixel(stim_rows[i].raw, stim_rows[i].frame_start, stim_rows[i].line_end,
                       stim_rows[i].check, stim_rows[i].given);
         end
      end

      // Random phases; phases do not restart the frame, so stride changes land mid-frame
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: s = reset_settings();
            1: begin
               s = '1;
               s.max_range   = '0;
               s.sample_step = 5'd1;
            end
            2: s = '0;
            default: begin
               s.depth_scale = spread24();
               s.principal_x = dpd_pkg::PRIN_W'($urandom);
               s.principal_y = dpd_pkg::PRIN_W'($urandom);
               s.inv_focal_x = spread24();
               s.inv_focal_y = spread24();
               s.min_range   = $urandom_range(0, 1) ? spread24() : '0;
               s.max_range   = $urandom_range(0, 1) ? spread24() : '0;
               s.sample_step = ($urandom_range(0, 3) == 0) ?
                               dpd_pkg::STEP_W'($urandom_range(0, 31)) :
                               dpd_pkg::STEP_W'($urandom_range(1, 3));
               if (p == 3) begin
                  s.max_range   = '1;
                  s.sample_step = dpd_pkg::STEP_W'($urandom_range(17, 31));
               end
            end
         endcase
         apply_settings(s);
         tx_steady = (p == 0) || ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         // Back up the output with a long stall while pixels keep coming
         if (p == 0) hold_request = 1'b1;
         stream_frames(PHASE_ITEMS);
      end

      // One long line at the coarsest stride
      s = '1;
      s.principal_x = '0;
      s.principal_y = '0;
      s.min_range   = '0;
      s.max_range   = '0;
      s.sample_step = 5'd16;
      apply_settings(s);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      for (int i = 0; i < TAIL_ITEMS; i++) send_pixel(random_raw(), i == 0, i == TAIL_ITEMS - 1);

      // One-pixel lines: only the row counter and its phase move
      s.sample_step = dpd_pkg::STEP_W'($urandom_range(1, 2));
      apply_settings(s);
      for (int i = 0; i < TAIL_ITEMS; i++) send_pixel(random_raw(), i == 0, 1'b1);

      drain_points();
      $display("covered %0d pixels under %0d register sets, %0d points checked",
               pixels_sent, settings_applied, points_checked);
      $display("output held off for %0d long stretches; %0d errors", long_stalls, error_count);
      if (error_count == 0) begin
         $display("depth_pixel_deprojection_tb: done, clean");
      end else begin
         $display("depth_pixel_deprojection_tb: done, errors");
      end
      $finish;
   end

   // Receive points after random gaps and compare with the oldest expectation
   initial begin : point_checker
      int                 gap;
      dpd_pkg::point_type got;
      dpd_pkg::point_type want;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            pop <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            hold_request = 1'b0;
            long_stalls++;
         end
         gap = rx_steady ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         got.x = rsp_point_x;
         got.y = rsp_point_y;
         got.z = rsp_point_z;
         if (pending_points.size() == 0) begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
               $display("unexpected point: x %0d y %0d z %0d",
                        $signed(got.x), $signed(got.y), got.z);
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
               error_count++;
               if (error_count <= SHOW_LIMIT)
                  $display("point mismatch: x %0d/%0d y %0d/%0d z %0d/%0d (expected/actual)",
                           $signed(want.x), $signed(got.x), $signed(want.y), $signed(got.y),
                           want.z, got.z);
            end
         end
      end
   end

   // Hard bound on run time
   initial begin : watchdog
      #8_000_000;
      $display("timeout with %0d points outstanding", pending_points.size());
      $display("depth_pixel_deprojection_tb: done, errors");
      $finish;
   end

endmodule
